@@ src/beat_time_arith_convert_defines.svh @@
// Assertion macros shared by the beat time arithmetic and conversion block.
`ifndef BEAT_TIME_ARITH_CONVERT_DEFINES_SVH
`define BEAT_TIME_ARITH_CONVERT_DEFINES_SVH
`ifndef SYNTHESIS
`define BTAC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define BTAC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BTAC_ASSERT(lbl, clk, rstn, prop, msg)
`define BTAC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

@@ src/btac_pkg.sv @@
// Types and constants of the beat time arithmetic and conversion block.
`default_nettype none
package btac_pkg;

    localparam int BEATS_W  = 64;
    localparam int REM_W    = 30;
    localparam int FRAMES_W = 32;
    localparam int FUNC_W   = 3;
    localparam int ORDER_W  = 2;
    localparam int TEMPO_W  = 32;
    localparam int RATE_W   = 20;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 1;
    localparam int IN_DATA_W  = 224;
    localparam int OUT_DATA_W = 128;
    localparam int OUT_USER_W = 2;

    // Sequencer datapath widths
    localparam int ACC_W  = 128;
    localparam int DV_W   = 63;
    localparam int K_W    = 42;
    localparam int CNT_W  = 6;
    localparam int DIVB_STEPS = 43;
    localparam int FRM_STEPS  = 32;
    localparam int Q16_SHIFT  = 16;
    localparam int SECS_PER_MIN = 60;
    localparam logic [BEATS_W-1:0] BEAT_CAP = 64'h0000_0800_0000_0000;

    localparam logic [TEMPO_W-1:0] TEMPO_RESET = 32'd7864320;
    localparam logic [RATE_W-1:0]  RATE_RESET  = 20'd48000;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TEMPO = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_RATE  = 1'b1;

    // Function codes on the input
    localparam logic [FUNC_W-1:0] FUNC_ADD = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_SUB = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_CMP = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_T2F = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_F2T = 3'd4;

    // Compare results
    localparam logic [ORDER_W-1:0] ORD_LESS = 2'd0;
    localparam logic [ORDER_W-1:0] ORD_EQ   = 2'd1;
    localparam logic [ORDER_W-1:0] ORD_GT   = 2'd2;

    typedef enum logic [2:0] {
        OP_ADD,
        OP_SUB,
        OP_CMP,
        OP_T2F,
        OP_F2T,
        OP_NONE
    } op_t;

    typedef struct packed {
        op_t                 op;
        logic [BEATS_W-1:0]  a_beats;
        logic [REM_W-1:0]    a_rem;
        logic [BEATS_W-1:0]  b_beats;
        logic [REM_W-1:0]    b_rem;
        logic [FRAMES_W-1:0] frames;
    } item_t;

    typedef struct packed {
        logic has_item;
        logic full;
    } q_stat_t;

endpackage
`default_nettype wire

@@ src/beat_time_arith_convert.sv @@
// Top level of the beat time arithmetic and conversion block.
//
// Input channel s_*: one request per transfer; s_tuser carries the function
// (add, subtract, compare, time to frames, frames to time), s_tdata the two
// times and a frame count. Output channel m_*: one result per request, in
// request order. Configuration: cfg_wr_en writes cfg_wdata to register
// cfg_index (0 tempo, Q16.16 BPM; 1 sample rate); write only while idle.
// Add, subtract, compare and the error cases of the conversions load the
// output register from the queue head, one per cycle while the receiver is
// ready and no long conversion runs. Time to frames runs a shift-add
// multiplier and a restoring divider in the back end: times BEAT_UNITS, times
// the frame scale, divide. Frames to time: divide, multiply the rest, divide.
// One long conversion runs at a time; a four-entry queue keeps accepting
// input while it runs. Reset (aresetn low, synchronous) empties the queue,
// drops m_tvalid and restores tempo 120 BPM and 48000 frames per second.
// A stalled receiver holds the result in the output register; the back end
// then stops and the queue fills before s_tready drops.
`default_nettype none
module beat_time_arith_convert #(
    parameter int BEAT_UNITS = 882161280
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [btac_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [btac_pkg::CFG_W-1:0]        cfg_wdata,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // a_beats, a_rem, b_beats, b_rem, frame_count_in, zero fill
    input  wire logic [btac_pkg::IN_DATA_W-1:0]    s_tdata,
    // func
    input  wire logic [btac_pkg::FUNC_W-1:0]       s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // out_beats, out_rem, out_frames, order
    output logic [btac_pkg::OUT_DATA_W-1:0]        m_tdata,
    // saturated, bad_operand
    output logic [btac_pkg::OUT_USER_W-1:0]        m_tuser
);

    logic [btac_pkg::TEMPO_W-1:0] tempo_reg;
    logic [btac_pkg::RATE_W-1:0]  rate_reg;
    btac_pkg::item_t              push_item;
    btac_pkg::item_t              head_item;
    btac_pkg::q_stat_t            q_stat;
    logic                         push;
    logic                         pop;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tempo_reg <= btac_pkg::TEMPO_RESET;
            rate_reg  <= btac_pkg::RATE_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                btac_pkg::REG_TEMPO: tempo_reg <= cfg_wdata;
                btac_pkg::REG_RATE:  rate_reg  <= cfg_wdata[btac_pkg::RATE_W-1:0];
                default:             tempo_reg <= tempo_reg;
            endcase
        end
    end

    btac_front #(
        .BEAT_UNITS (BEAT_UNITS)
    ) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_stat   (q_stat),
        .push     (push),
        .item     (push_item)
    );

    btac_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .din     (push_item),
        .pop     (pop),
        .dout    (head_item),
        .stat    (q_stat)
    );

    btac_back #(
        .BEAT_UNITS (BEAT_UNITS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head_item),
        .q_stat   (q_stat),
        .pop      (pop),
        .tempo    (tempo_reg),
        .rate     (rate_reg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
`default_nettype wire

@@ src/btac_front.sv @@
// Front end: unpacks input transfers, clamps remainders and decodes the function.
`default_nettype none
module btac_front #(
    parameter int BEAT_UNITS = 882161280
) (
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [btac_pkg::IN_DATA_W-1:0]  s_tdata,
    input  wire logic [btac_pkg::FUNC_W-1:0]     s_tuser,
    input  wire btac_pkg::q_stat_t               q_stat,
    output logic                                 push,
    output btac_pkg::item_t                      item
);

    localparam logic [31:0] BU32 = 32'(BEAT_UNITS);
    localparam logic [btac_pkg::REM_W-1:0] REM_MAX = btac_pkg::REM_W'(BEAT_UNITS - 1);

    logic [btac_pkg::REM_W-1:0] a_rem_raw;
    logic [btac_pkg::REM_W-1:0] b_rem_raw;

    assign a_rem_raw = s_tdata[93:64];
    assign b_rem_raw = s_tdata[187:158];

    // Accept while the queue has room
    assign s_tready = !q_stat.full;
    assign push     = s_tvalid && !q_stat.full;

    // Clamp out-of-range remainders and decode the function code
    always_comb begin
        item.a_beats = s_tdata[63:0];
        item.b_beats = s_tdata[157:94];
        item.frames  = s_tdata[219:188];
        item.a_rem   = (32'(a_rem_raw) >= BU32) ? REM_MAX : a_rem_raw;
        item.b_rem   = (32'(b_rem_raw) >= BU32) ? REM_MAX : b_rem_raw;
        case (s_tuser)
            btac_pkg::FUNC_ADD: item.op = btac_pkg::OP_ADD;
            btac_pkg::FUNC_SUB: item.op = btac_pkg::OP_SUB;
            btac_pkg::FUNC_CMP: item.op = btac_pkg::OP_CMP;
            btac_pkg::FUNC_T2F: item.op = btac_pkg::OP_T2F;
            btac_pkg::FUNC_F2T: item.op = btac_pkg::OP_F2T;
            default:            item.op = btac_pkg::OP_NONE;
        endcase
    end

endmodule
`default_nettype wire

@@ src/btac_queue.sv @@
// Short item queue between the front end and the execution back end.
`default_nettype none
module btac_queue (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  wire btac_pkg::item_t din,
    input  wire logic            pop,
    output btac_pkg::item_t      dout,
    output btac_pkg::q_stat_t    stat
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    btac_pkg::item_t  entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;

    assign dout          = entry_reg[rd_ptr_reg];
    assign stat.has_item = (count_reg != '0);
    assign stat.full     = (count_reg == (PTR_W + 1)'(DEPTH));

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store pushed items
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= din;
        end
    end

endmodule
`default_nettype wire

@@ src/btac_back.sv @@
// Back end: executes queued items and holds the result transfer register.
`default_nettype none
`include "beat_time_arith_convert_defines.svh"
module btac_back #(
    parameter int BEAT_UNITS = 882161280
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire btac_pkg::item_t                  head,
    input  wire btac_pkg::q_stat_t                q_stat,
    output logic                                  pop,
    input  wire logic [btac_pkg::TEMPO_W-1:0]     tempo,
    input  wire logic [btac_pkg::RATE_W-1:0]      rate,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [btac_pkg::OUT_DATA_W-1:0]       m_tdata,
    output logic [btac_pkg::OUT_USER_W-1:0]       m_tuser
);

    localparam int BU_W = $clog2(BEAT_UNITS + 1);
    localparam logic [31:0] BU32 = 32'(BEAT_UNITS);
    localparam int ACC_W = btac_pkg::ACC_W;
    localparam int BW = btac_pkg::BEATS_W;
    localparam int DV_W = btac_pkg::DV_W;
    localparam int K_W = btac_pkg::K_W;
    localparam int CNT_W = btac_pkg::CNT_W;
    localparam int REM_W = btac_pkg::REM_W;
    localparam int FW = btac_pkg::FRAMES_W;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_MULBU = 7'b0000010,
        ST_MULK  = 7'b0000100,
        ST_RANGE = 7'b0001000,
        ST_DIVB  = 7'b0010000,
        ST_DIV   = 7'b0100000,
        ST_DONE  = 7'b1000000
    } state_t;

    state_t             st_reg, st_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic [ACC_W-1:0]   mcand_reg, mcand_next;
    logic [K_W-1:0]     mplier_reg, mplier_next;
    logic [BW-1:0]      rr_reg, rr_next;
    logic [BW-1:0]      num_reg, num_next;
    logic [BW-1:0]      q_reg, q_next;
    logic [DV_W-1:0]    dv_reg, dv_next;
    logic               is_t2f_reg, is_t2f_next;
    logic [BW-1:0]      res_beats_reg, res_beats_next;
    logic [REM_W-1:0]   res_rem_reg, res_rem_next;
    logic [FW-1:0]      res_frames_reg, res_frames_next;
    logic               res_sat_reg, res_sat_next;

    logic               out_valid_reg, out_valid_next;
    logic [BW-1:0]      out_beats_reg, out_beats_next;
    logic [REM_W-1:0]   out_rem_reg, out_rem_next;
    logic [FW-1:0]      out_frames_reg, out_frames_next;
    logic [btac_pkg::ORDER_W-1:0] out_order_reg, out_order_next;
    logic               out_sat_reg, out_sat_next;
    logic               out_bad_reg, out_bad_next;

    // Shared shift-add multiplier and restoring divider steps
    logic [ACC_W-1:0]   acc_add;
    logic [BW-1:0]      div_sh;
    logic               div_ge;
    logic [BW-1:0]      div_rr;
    logic [BW-1:0]      div_q;
    logic [K_W-1:0]     k_base;
    logic [K_W-1:0]     k_val;
    logic [DV_W-1:0]    dv_t2f;
    logic [BW-1:0]      p_f2t;
    logic [ACC_W-1:0]   range_lim;
    logic               range_sat;
    logic [BW-1:0]      b_clip;

    // Combinational results
    logic [31:0]        add_sum;
    logic               add_carry;
    logic [31:0]        add_rem;
    logic               sub_ge;
    logic [31:0]        sub_rem;
    logic [btac_pkg::ORDER_W-1:0] cmp_order;
    logic [BW-1:0]      fast_beats;
    logic [REM_W-1:0]   fast_rem;
    logic [FW-1:0]      fast_frames;
    logic [btac_pkg::ORDER_W-1:0] fast_order;
    logic               fast_sat;
    logic               fast_bad;

    logic               can_load;
    logic               head_slow;
    logic               load_fast;
    logic               load_done;

    assign acc_add = acc_reg + (mplier_reg[0] ? mcand_reg : '0);
    assign div_sh  = {rr_reg[BW-2:0], num_reg[BW-1]};
    assign div_ge  = (div_sh >= {1'b0, dv_reg});
    assign div_rr  = div_ge ? div_sh - {1'b0, dv_reg} : div_sh;
    assign div_q   = {q_reg[BW-2:0], div_ge};

    assign k_base    = K_W'(rate) * K_W'(btac_pkg::SECS_PER_MIN);
    assign k_val     = k_base << btac_pkg::Q16_SHIFT;
    assign dv_t2f    = DV_W'(64'(BEAT_UNITS) * 64'(tempo));
    assign p_f2t     = 64'(head.frames) * 64'(tempo);
    assign range_lim = {{(ACC_W - DV_W - FW){1'b0}}, dv_reg, {FW{1'b0}}};
    assign range_sat = (acc_reg >= range_lim);
    assign b_clip    = (head.a_beats > btac_pkg::BEAT_CAP) ? btac_pkg::BEAT_CAP : head.a_beats;

    assign add_sum   = 32'(head.a_rem) + 32'(head.b_rem);
    assign add_carry = (add_sum >= BU32);
    assign add_rem   = add_carry ? add_sum - BU32 : add_sum;
    assign sub_ge    = (head.a_rem >= head.b_rem);
    assign sub_rem   = sub_ge ? 32'(head.a_rem) - 32'(head.b_rem)
                              : 32'(head.a_rem) + BU32 - 32'(head.b_rem);

    // Order: signed beats first, then remainder
    always_comb begin
        if ($signed(head.a_beats) < $signed(head.b_beats)) begin
            cmp_order = btac_pkg::ORD_LESS;
        end else if ($signed(head.a_beats) > $signed(head.b_beats)) begin
            cmp_order = btac_pkg::ORD_GT;
        end else if (head.a_rem < head.b_rem) begin
            cmp_order = btac_pkg::ORD_LESS;
        end else if (head.a_rem > head.b_rem) begin
            cmp_order = btac_pkg::ORD_GT;
        end else begin
            cmp_order = btac_pkg::ORD_EQ;
        end
    end

    // Results that need no sequencer
    always_comb begin
        fast_beats  = '0;
        fast_rem    = '0;
        fast_frames = '0;
        fast_order  = btac_pkg::ORD_LESS;
        fast_sat    = 1'b0;
        fast_bad    = 1'b0;
        case (head.op)
            btac_pkg::OP_ADD: begin
                fast_beats = head.a_beats + head.b_beats + BW'(add_carry);
                fast_rem   = add_rem[REM_W-1:0];
            end
            btac_pkg::OP_SUB: begin
                fast_beats = head.a_beats - head.b_beats - BW'(!sub_ge);
                fast_rem   = sub_rem[REM_W-1:0];
            end
            btac_pkg::OP_CMP: begin
                fast_order = cmp_order;
            end
            btac_pkg::OP_T2F: begin
                if (head.a_beats[BW-1]) begin
                    fast_bad = 1'b1;
                end else begin
                    fast_frames = '1;
                    fast_sat    = 1'b1;
                end
            end
            btac_pkg::OP_F2T: begin
                fast_bad = 1'b1;
            end
            default: begin
                fast_bad = 1'b0;
            end
        endcase
    end

    assign can_load  = !out_valid_reg || m_tready;
    assign head_slow = ((head.op == btac_pkg::OP_T2F) && !head.a_beats[BW-1]
                        && (tempo != '0))
                    || ((head.op == btac_pkg::OP_F2T) && (rate != '0));
    assign pop       = (st_reg == ST_IDLE) && q_stat.has_item && (head_slow || can_load);
    assign load_fast = (st_reg == ST_IDLE) && q_stat.has_item && !head_slow && can_load;
    assign load_done = (st_reg == ST_DONE) && can_load;

    // Sequencer
    always_comb begin
        st_next         = st_reg;
        cnt_next        = cnt_reg;
        acc_next        = acc_reg;
        mcand_next      = mcand_reg;
        mplier_next     = mplier_reg;
        rr_next         = rr_reg;
        num_next        = num_reg;
        q_next          = q_reg;
        dv_next         = dv_reg;
        is_t2f_next     = is_t2f_reg;
        res_beats_next  = res_beats_reg;
        res_rem_next    = res_rem_reg;
        res_frames_next = res_frames_reg;
        res_sat_next    = res_sat_reg;
        case (st_reg)
            ST_IDLE: begin
                if (pop && head_slow) begin
                    res_beats_next  = '0;
                    res_rem_next    = '0;
                    res_frames_next = '0;
                    res_sat_next    = 1'b0;
                    if (head.op == btac_pkg::OP_T2F) begin
                        // beats * units + rem, then times the frame scale
                        is_t2f_next = 1'b1;
                        acc_next    = ACC_W'(head.a_rem);
                        mcand_next  = ACC_W'(b_clip);
                        mplier_next = K_W'(BEAT_UNITS);
                        cnt_next    = CNT_W'(BU_W - 1);
                        dv_next     = dv_t2f;
                        st_next     = ST_MULBU;
                    end else begin
                        // whole beats first: frames * tempo over the frame scale
                        is_t2f_next = 1'b0;
                        rr_next     = p_f2t >> btac_pkg::DIVB_STEPS;
                        num_next    = p_f2t << (BW - btac_pkg::DIVB_STEPS);
                        q_next      = '0;
                        cnt_next    = CNT_W'(btac_pkg::DIVB_STEPS - 1);
                        dv_next     = DV_W'(k_val);
                        st_next     = ST_DIVB;
                    end
                end
            end
            ST_MULBU, ST_MULK: begin
                acc_next    = acc_add;
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                cnt_next    = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    if ((st_reg == ST_MULBU) && is_t2f_reg) begin
                        acc_next    = '0;
                        mcand_next  = acc_add;
                        mplier_next = k_val;
                        cnt_next    = CNT_W'(K_W - 1);
                        st_next     = ST_MULK;
                    end else begin
                        st_next = ST_RANGE;
                    end
                end
            end
            ST_RANGE: begin
                q_next = '0;
                if (is_t2f_reg) begin
                    if (range_sat) begin
                        res_frames_next = '1;
                        res_sat_next    = 1'b1;
                        st_next         = ST_DONE;
                    end else begin
                        rr_next  = acc_reg[FW +: BW];
                        num_next = {acc_reg[FW-1:0], {(BW - FW){1'b0}}};
                        cnt_next = CNT_W'(btac_pkg::FRM_STEPS - 1);
                        st_next  = ST_DIV;
                    end
                end else begin
                    rr_next  = BW'(acc_reg >> BU_W);
                    num_next = BW'(acc_reg[BU_W-1:0]) << (BW - BU_W);
                    cnt_next = CNT_W'(BU_W - 1);
                    st_next  = ST_DIV;
                end
            end
            ST_DIVB: begin
                rr_next  = div_rr;
                num_next = num_reg << 1;
                q_next   = div_q;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    // scale the leftover to beat units
                    res_beats_next = div_q;
                    acc_next       = '0;
                    mcand_next     = ACC_W'(div_rr);
                    mplier_next    = K_W'(BEAT_UNITS);
                    cnt_next       = CNT_W'(BU_W - 1);
                    st_next        = ST_MULBU;
                end
            end
            ST_DIV: begin
                rr_next  = div_rr;
                num_next = num_reg << 1;
                q_next   = div_q;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    if (is_t2f_reg) begin
                        res_frames_next = div_q[FW-1:0];
                        res_sat_next    = (&div_q[FW-1:0]) && (div_rr != '0);
                    end else begin
                        res_rem_next = div_q[REM_W-1:0];
                    end
                    st_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (can_load) begin
                    st_next = ST_IDLE;
                end
            end
            default: begin
                st_next = ST_IDLE;
            end
        endcase
    end

    // Output register: load on a free slot, drop valid after the transfer
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_beats_next  = out_beats_reg;
        out_rem_next    = out_rem_reg;
        out_frames_next = out_frames_reg;
        out_order_next  = out_order_reg;
        out_sat_next    = out_sat_reg;
        out_bad_next    = out_bad_reg;
        if (load_fast) begin
            out_valid_next  = 1'b1;
            out_beats_next  = fast_beats;
            out_rem_next    = fast_rem;
            out_frames_next = fast_frames;
            out_order_next  = fast_order;
            out_sat_next    = fast_sat;
            out_bad_next    = fast_bad;
        end else if (load_done) begin
            out_valid_next  = 1'b1;
            out_beats_next  = res_beats_reg;
            out_rem_next    = res_rem_reg;
            out_frames_next = res_frames_reg;
            out_order_next  = btac_pkg::ORD_LESS;
            out_sat_next    = res_sat_reg;
            out_bad_next    = 1'b0;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg        <= ST_IDLE;
            out_valid_reg <= 1'b0;
            out_sat_reg   <= 1'b0;
            out_bad_reg   <= 1'b0;
        end else begin
            st_reg        <= st_next;
            out_valid_reg <= out_valid_next;
            out_sat_reg   <= out_sat_next;
            out_bad_reg   <= out_bad_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg        <= cnt_next;
        acc_reg        <= acc_next;
        mcand_reg      <= mcand_next;
        mplier_reg     <= mplier_next;
        rr_reg         <= rr_next;
        num_reg        <= num_next;
        q_reg          <= q_next;
        dv_reg         <= dv_next;
        is_t2f_reg     <= is_t2f_next;
        res_beats_reg  <= res_beats_next;
        res_rem_reg    <= res_rem_next;
        res_frames_reg <= res_frames_next;
        res_sat_reg    <= res_sat_next;
        out_beats_reg  <= out_beats_next;
        out_rem_reg    <= out_rem_next;
        out_frames_reg <= out_frames_next;
        out_order_reg  <= out_order_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_order_reg, out_frames_reg, out_rem_reg, out_beats_reg};
    assign m_tuser  = {out_bad_reg, out_sat_reg};

    `BTAC_ASSERT_ALWAYS(a_reset_clears, aclk, !aresetn |=> (!out_valid_reg && st_reg == ST_IDLE), "reset left output or sequencer busy")
    `BTAC_ASSERT(a_done_holds, aclk, aresetn, (st_reg == ST_DONE && out_valid_reg && !m_tready) |=> (st_reg == ST_DONE), "finished result lost while output stalled")
    `BTAC_ASSERT(a_slow_start, aclk, aresetn, (pop && head_slow) |=> (st_reg == ST_MULBU || st_reg == ST_DIVB), "long operation did not start")
    `BTAC_ASSERT(a_flags_excl, aclk, aresetn, out_valid_reg |-> !(out_sat_reg && out_bad_reg), "saturated and bad operand both set")

endmodule
`default_nettype wire

@@ test/btac_checker.sv @@
// Checker for the beat time block: predicts each result and compares it.
`timescale 1ns / 100ps
module btac_checker
    import btac_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [CFG_W-1:0]         cfg_wdata,
    input  wire logic                     s_tvalid,
    input  wire logic                     s_tready,
    input  wire logic [IN_DATA_W-1:0]     s_tdata,
    input  wire logic [FUNC_W-1:0]        s_tuser,
    input  wire logic                     m_tvalid,
    input  wire logic                     m_tready,
    input  wire logic [OUT_DATA_W-1:0]    m_tdata,
    input  wire logic [OUT_USER_W-1:0]    m_tuser,
    output int                            err_count,
    output int                            pending,
    output int                            seen_count
);

    localparam logic [63:0] UNITS_PER_BEAT = 64'd882161280;
    localparam logic [63:0] FRAMES_MAX     = 64'hFFFF_FFFF;

    typedef struct {
        logic [BEATS_W-1:0]  beats;
        logic [REM_W-1:0]    rem;
        logic [FRAMES_W-1:0] frames;
        logic [ORDER_W-1:0]  order;
        logic                sat;
        logic                bad;
    } time_result_t;

    logic [TEMPO_W-1:0] tempo_q16;
    logic [RATE_W-1:0]  rate;
    time_result_t       expected_results[$];

    function automatic logic [63:0] clip_rem(input logic [REM_W-1:0] r);
        return (64'(r) >= UNITS_PER_BEAT) ? UNITS_PER_BEAT - 1 : 64'(r);
    endfunction

    // Work out the result of one request under the current tempo and rate
    function automatic time_result_t calc_time_result(input logic [FUNC_W-1:0] fn,
            input logic [63:0] ab, input logic [REM_W-1:0] ar_raw,
            input logic [63:0] bb, input logic [REM_W-1:0] br_raw,
            input logic [31:0] frm);
        time_result_t res;
        logic [63:0]  ar, br, rsum, bcap, prod, span;
        logic [127:0] num, den, quo;
        ar = clip_rem(ar_raw);
        br = clip_rem(br_raw);
        res = '{default: '0};
        case (fn)
            FUNC_ADD: begin
                res.beats = ab + bb;
                rsum = ar + br;
                if (rsum >= UNITS_PER_BEAT) begin
                    res.beats = res.beats + 1;
                    rsum = rsum - UNITS_PER_BEAT;
                end
                res.rem = rsum[REM_W-1:0];
            end
            FUNC_SUB: begin
                res.beats = ab - bb;
                if (ar >= br) begin
                    rsum = ar - br;
                end else begin
                    rsum = ar + UNITS_PER_BEAT - br;
                    res.beats = res.beats - 1;
                end
                res.rem = rsum[REM_W-1:0];
            end
            FUNC_CMP: begin
                if ($signed(ab) < $signed(bb)) res.order = ORD_LESS;
                else if ($signed(ab) > $signed(bb)) res.order = ORD_GT;
                else if (ar < br) res.order = ORD_LESS;
                else if (ar > br) res.order = ORD_GT;
                else res.order = ORD_EQ;
            end
            FUNC_T2F: begin
                if (ab[63]) begin
                    res.bad = 1'b1;
                end else if (tempo_q16 == '0) begin
                    res.frames = '1;
                    res.sat = 1'b1;
                end else begin
                    bcap = (ab > BEAT_CAP) ? BEAT_CAP : ab;
                    num = (128'(bcap) * 128'(UNITS_PER_BEAT) + 128'(ar))
                          * (128'(SECS_PER_MIN) * 128'(rate) * 128'(65536));
                    den = 128'(UNITS_PER_BEAT) * 128'(tempo_q16);
                    quo = num / den;
                    // a fractional part above the top count still clips
                    if (quo > 128'(FRAMES_MAX) ||
                            (quo == 128'(FRAMES_MAX) && (num % den) != 0)) begin
                        res.frames = '1;
                        res.sat = 1'b1;
                    end else begin
                        res.frames = quo[31:0];
                    end
                end
            end
            FUNC_F2T: begin
                if (rate == '0) begin
                    res.bad = 1'b1;
                end else begin
                    span = 64'(SECS_PER_MIN) * 64'(65536) * 64'(rate);
                    prod = 64'(frm) * 64'(tempo_q16);
                    res.beats = prod / span;
                    quo = (128'(prod % span) * 128'(UNITS_PER_BEAT)) / 128'(span);
                    res.rem = quo[REM_W-1:0];
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    assign pending = expected_results.size();

    // Track registers, queue predictions, check results
    always @(posedge aclk) begin
        time_result_t exp_r;
        if (!aresetn) begin
            tempo_q16 <= TEMPO_RESET;
            rate <= RATE_RESET;
            expected_results.delete();
            err_count <= 0;
            seen_count <= 0;
        end else begin
            if (cfg_wr_en) begin
                if (cfg_index == REG_TEMPO) tempo_q16 <= cfg_wdata[TEMPO_W-1:0];
                else if (cfg_index == REG_RATE) rate <= cfg_wdata[RATE_W-1:0];
            end
            if (s_tvalid && s_tready) begin
                expected_results.push_back(calc_time_result(s_tuser, s_tdata[63:0],
                    s_tdata[93:64], s_tdata[157:94], s_tdata[187:158],
                    s_tdata[219:188]));
            end
            if (m_tvalid && m_tready) begin
                seen_count <= seen_count + 1;
                if (expected_results.size() == 0) begin
                    $error("result transfer with nothing expected");
                    err_count <= err_count + 1;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (m_tdata[63:0] !== exp_r.beats ||
                            m_tdata[93:64] !== exp_r.rem ||
                            m_tdata[125:94] !== exp_r.frames ||
                            m_tdata[127:126] !== exp_r.order ||
                            m_tuser[0] !== exp_r.sat || m_tuser[1] !== exp_r.bad)
                        err_count <= err_count + 1;
                    if (m_tdata[63:0] !== exp_r.beats)
                        $error("out_beats: expected %h, got %h", exp_r.beats, m_tdata[63:0]);
                    if (m_tdata[93:64] !== exp_r.rem)
                        $error("out_rem: expected %0d, got %0d", exp_r.rem, m_tdata[93:64]);
                    if (m_tdata[125:94] !== exp_r.frames)
                        $error("out_frames: expected %0d, got %0d", exp_r.frames,
                               m_tdata[125:94]);
                    if (m_tdata[127:126] !== exp_r.order)
                        $error("order: expected %0d, got %0d", exp_r.order,
                               m_tdata[127:126]);
                    if (m_tuser[0] !== exp_r.sat)
                        $error("saturated: expected %0b, got %0b", exp_r.sat, m_tuser[0]);
                    if (m_tuser[1] !== exp_r.bad)
                        $error("bad_operand: expected %0b, got %0b", exp_r.bad, m_tuser[1]);
                end
            end
        end
    end

endmodule

@@ test/tb.sv @@
// Top of the beat time block testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module tb;
    import btac_pkg::*;

    localparam int          SETTLE_CYCLES = 200;
    localparam logic [29:0] UNITS_LAST    = 30'd882161279;
    localparam logic [63:0] BEATS_MIN     = 64'h8000_0000_0000_0000;
    localparam logic [63:0] BEATS_MAX     = 64'h7FFF_FFFF_FFFF_FFFF;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]      cfg_wdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [FUNC_W-1:0]     s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [OUT_USER_W-1:0] m_tuser;

    int err_count, pending, seen_count;
    int sent_count = 0;
    int cfg_count = 0;
    bit quiet = 1'b0;
    bit hold_req = 1'b0;
    bit hold_done = 1'b0;

    beat_time_arith_convert u_top (
        .aclk, .aresetn, .cfg_wr_en, .cfg_index, .cfg_wdata,
        .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser
    );

    btac_checker u_checker (
        .aclk, .aresetn, .cfg_wr_en, .cfg_index, .cfg_wdata,
        .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser,
        .err_count, .pending, .seen_count
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Result side: random stalls, one long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req && !hold_done) begin
                m_tready <= 1'b0;
                repeat (600) @(posedge aclk);
                hold_done = 1'b1;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Offer one request and hold it until the transfer
    task automatic send_req(input logic [FUNC_W-1:0] fn, input logic [63:0] ab,
            input logic [29:0] ar, input logic [63:0] bb, input logic [29:0] br,
            input logic [31:0] frm);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= fn;
        s_tdata <= {4'b0, frm, br, bb, ar, ab};
        do @(posedge aclk); while (!s_tready);
        sent_count++;
    endtask

    // Drain results, let the back end settle, then write one register
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        s_tvalid <= 1'b0;
        // let the checker count the last transfer before draining
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cfg_count++;
    endtask

    function automatic logic [29:0] pick_rem();
        if ($urandom_range(0, 7) == 0) return 30'($urandom);
        return 30'($urandom_range(0, 882161279));
    endfunction

    function automatic logic [63:0] pick_beats(input logic [FUNC_W-1:0] fn);
        case ($urandom_range(0, 5))
            0: return {$urandom, $urandom};
            1: return $urandom_range(0, 1) ? BEATS_MAX - $urandom_range(0, 3)
                                           : BEATS_MIN + $urandom_range(0, 3);
            2: return 64'($signed(-$urandom_range(0, 400000)));
            default: return (fn == FUNC_T2F) ? 64'($urandom_range(0, 400000))
                                             : 64'($signed($urandom_range(0, 800000) - 400000));
        endcase
    endfunction

    // Random requests with an occasional unknown function code
    task automatic send_random(input int count);
        logic [FUNC_W-1:0] fn;
        logic [63:0]       ab;
        logic [29:0]       ar;
        for (int i = 0; i < count; i++) begin
            fn = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                              : 3'($urandom_range(0, 4));
            ab = pick_beats(fn);
            ar = pick_rem();
            // compare often sees equal beats so the remainder decides
            if (fn == FUNC_CMP && $urandom_range(0, 2) == 0)
                send_req(fn, ab, ar, ab, $urandom_range(0, 1) ? ar : pick_rem(), $urandom);
            else
                send_req(fn, ab, ar, pick_beats(fn), pick_rem(), $urandom);
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: carries, borrows, wraps, clipped remainders, orders, errors
        send_req(FUNC_ADD, 64'd5, UNITS_LAST, 64'd2, 30'd1, '0);
        send_req(FUNC_ADD, BEATS_MAX, UNITS_LAST, 64'd0, UNITS_LAST, '0);
        send_req(FUNC_ADD, 64'd1, 30'h3FFF_FFFF, 64'd1, 30'h3FFF_FFFF, '0);
        send_req(FUNC_SUB, 64'd3, 30'd0, 64'd1, 30'd1, '0);
        send_req(FUNC_SUB, BEATS_MIN, 30'd0, 64'd0, 30'd1, '0);
        send_req(FUNC_SUB, 64'd0, 30'h3FFF_FFFF, '1, 30'd0, '1);
        send_req(FUNC_CMP, '1, 30'd5, 64'd0, 30'd5, '0);
        send_req(FUNC_CMP, 64'd7, 30'd5, 64'd7, 30'd5, '0);
        send_req(FUNC_CMP, 64'd7, 30'h3FFF_FFFF, 64'd7, UNITS_LAST, '0);
        send_req(FUNC_CMP, 64'd7, 30'd6, 64'd7, 30'd5, '0);
        send_req(FUNC_CMP, BEATS_MAX, 30'd0, BEATS_MIN, 30'd0, '0);
        send_req(FUNC_T2F, 64'd0, 30'd0, '0, '0, '0);
        send_req(FUNC_T2F, 64'd1, 30'd0, '0, '0, '0);
        send_req(FUNC_T2F, '1, 30'd0, '0, '0, '0);
        send_req(FUNC_T2F, 64'd178956, UNITS_LAST, '0, '0, '0);
        send_req(FUNC_T2F, BEATS_MAX, 30'h3FFF_FFFF, '0, '0, '0);
        send_req(FUNC_F2T, '0, '0, '0, '0, 32'd0);
        send_req(FUNC_F2T, '0, '0, '0, '0, 32'd24001);
        send_req(FUNC_F2T, '1, '1, '1, '1, '1);
        send_req(3'd5, '1, '1, '1, '1, '1);
        send_req(3'd6, 64'd1, 30'd1, 64'd1, 30'd1, 32'd1);
        send_req(3'd7, '0, '0, '0, '0, '0);
        send_random(80);

        // Extreme and random settings, with one long receiver hold-off
        write_reg(REG_TEMPO, 32'hFFFF_FFFF);
        write_reg(REG_RATE, 32'd1);
        hold_req = 1'b1;
        send_random(90);
        write_reg(REG_TEMPO, 32'd1);
        write_reg(REG_RATE, 32'hFFFFF);
        send_random(90);
        write_reg(REG_TEMPO, 32'd0);
        send_random(60);
        write_reg(REG_RATE, 32'd0);
        write_reg(REG_TEMPO, $urandom);
        send_random(60);
        write_reg(REG_RATE, $urandom_range(1, 1048575));
        send_random(90);
        write_reg(REG_TEMPO, 32'd7864320);
        write_reg(REG_RATE, 32'd48000);
        quiet = 1'b1;
        send_random(80);
        s_tvalid <= 1'b0;

        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        $display("Ran %0d requests of every function over %0d register writes,", sent_count,
                 cfg_count);
        $display("including zero and full-scale tempo and rate; %0d results checked.",
                 seen_count);
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+src
src/btac_pkg.sv
src/btac_front.sv
src/btac_queue.sv
src/btac_back.sv
src/beat_time_arith_convert.sv
test/btac_checker.sv
test/tb.sv
